// ===== sv/cgpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgpa_pkg
// Shared types and codes for the chromosome active-node analysis block.
// ----------------------------------------------------------------------------
package cgpa_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_INPUTS = 16;
  localparam int MAX_OUTPUTS = 8;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ANALYSE = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_INPUTS = 3'd0,
    REG_OUTPUTS = 3'd1,
    REG_ROWS = 3'd2,
    REG_COLUMNS = 3'd3,
    REG_LEVELS = 3'd4,
    REG_FUNCTIONS = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_CHK_RD,
    ST_CHK,
    ST_CLR,
    ST_OUT_RD,
    ST_OUT_MARK,
    ST_SWEEP_RD,
    ST_SWEEP_MARK,
    ST_LIST_RD,
    ST_LIST,
    ST_OUTLIST,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/cgpa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgpa_if
// Valid/ready channels: command words in, result words out, register writes.
// ----------------------------------------------------------------------------
interface cgpa_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [7:0] gene_slot;
  logic [6:0] gene_value;
  logic [7:0] list_position;
  modport source (output valid, action, gene_slot, gene_value, list_position, input ready);
  modport sink (input valid, action, gene_slot, gene_value, list_position, output ready);
endinterface

interface cgpa_out_if;
  logic valid;
  logic ready;
  logic chromosome_valid;
  logic [6:0] active_node_count;
  logic [7:0] active_gene_count;
  logic [7:0] active_gene_slot;
  logic entry_in_range;
  modport source (output valid, chromosome_valid, active_node_count, active_gene_count,
                  active_gene_slot, entry_in_range, input ready);
  modport sink (input valid, chromosome_valid, active_node_count, active_gene_count,
                active_gene_slot, entry_in_range, output ready);
endinterface

interface cgpa_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/cgpa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgpa_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cgpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] addr,
  input wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/cgp_chromosome_active_analysis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgp_chromosome_active_analysis
// Stores a CGP chromosome, checks its genes, marks active nodes and builds
// the active gene list.
// ----------------------------------------------------------------------------
// Gene write: the next word can be taken on the next cycle after a write is accepted.
// List read: after acceptance the request passes through RDWAIT and RESULT; the result word is registered in RESULT.
// Analysis: checks every gene, clears the mark memory over its n+N entries for n inputs and N grid nodes,
// marks the active nodes and builds the active gene list; a failed check ends early.
// One word is in flight at a time. Reset sets all configuration registers to 1 and clears the
// totals; the RAM contents need no clearing.
module cgp_chromosome_active_analysis (
  input wire logic clk,
  input wire logic rst,
  cgpa_in_if.sink in_ch,
  cgpa_out_if.source out_ch,
  cgpa_cfg_if.sink cfg
);
  localparam int GDEPTH = 3 * cgpa_pkg::MAX_NODES + cgpa_pkg::MAX_OUTPUTS;
  localparam int MDEPTH = cgpa_pkg::MAX_INPUTS + cgpa_pkg::MAX_NODES;
  localparam int GA = $clog2(GDEPTH);
  localparam int MA = $clog2(MDEPTH);
  localparam int W = 16;

  cgpa_pkg::state_t state, state_next;
  logic [4:0] n_in, n_fn;
  logic [3:0] n_out;
  logic [6:0] n_rows, n_cols, lvl;
  logic [7:0] gene_total;
  logic [6:0] node_total;
  logic [W-1:0] nodes, genome;
  logic [W-1:0] idx, col, row, cnt, len;
  logic [1:0] sub;
  logic [W-1:0] lo, hi;
  logic res_ok, res_read;
  logic [7:0] res_slot;
  logic [1:0] mode;

  logic g_we;
  logic [GA-1:0] g_addr;
  logic [6:0] g_wdata, g_rdata;
  logic l_we;
  logic [GA-1:0] l_addr;
  logic [7:0] l_wdata, l_rdata;
  logic m_we;
  logic [MA-1:0] m_addr;
  logic m_wdata, m_rdata;

  cgpa_ram #(.WIDTH(7), .DEPTH(GDEPTH)) u_gene (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata));
  cgpa_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_list (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
  cgpa_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_mark (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));

  assign cfg.ready = 1'b1;
  assign nodes = W'(n_rows) * W'(n_cols);
  assign genome = 16'd3 * nodes + W'(n_out);

  logic fits;
  assign fits = n_in != 0 && n_out != 0 && n_rows != 0 && n_cols != 0 && lvl != 0 &&
                n_fn != 0 && W'(n_in) <= W'(cgpa_pkg::MAX_INPUTS) &&
                W'(n_out) <= W'(cgpa_pkg::MAX_OUTPUTS) &&
                nodes <= W'(cgpa_pkg::MAX_NODES);

  assign in_ch.ready = state == cgpa_pkg::ST_IDLE && !out_ch.valid;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // Gene address for each pass.
  logic [W-1:0] g_addr_w;
  always_comb begin
    g_we = 1'b0;
    g_wdata = in_ch.gene_value;
    g_addr_w = W'(in_ch.gene_slot);
    case (state)
      cgpa_pkg::ST_IDLE: begin
        g_we = acc && in_ch.action == cgpa_pkg::ACT_WRITE &&
               W'(in_ch.gene_slot) < genome && W'(in_ch.gene_slot) < W'(GDEPTH);
      end
      cgpa_pkg::ST_CHK_RD: g_addr_w = idx;
      cgpa_pkg::ST_OUT_RD: g_addr_w = 16'd3 * nodes + cnt;
      cgpa_pkg::ST_SWEEP_RD: g_addr_w = 16'd3 * (idx - W'(n_in)) + W'(sub);
      default: g_addr_w = idx;
    endcase
  end
  assign g_addr = g_addr_w[GA-1:0];

  always_comb begin
    m_we = 1'b0;
    m_wdata = 1'b1;
    m_addr = idx[MA-1:0];
    case (state)
      cgpa_pkg::ST_CLR: begin
        m_we = 1'b1;
        m_wdata = 1'b0;
      end
      cgpa_pkg::ST_OUT_MARK: begin
        m_we = 1'b1;
        m_addr = g_rdata[MA-1:0];
      end
      cgpa_pkg::ST_SWEEP_MARK: begin
        m_we = m_rdata;
        m_addr = g_rdata[MA-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    l_we = state == cgpa_pkg::ST_LIST && mode == 2'd1 ||
           state == cgpa_pkg::ST_OUTLIST;
    l_addr = len[GA-1:0];
    l_wdata = state == cgpa_pkg::ST_OUTLIST ? 8'(16'd3 * nodes + cnt)
                                            : 8'(16'd3 * (idx - W'(n_in)) + W'(sub));
    if (state == cgpa_pkg::ST_IDLE) begin
      l_addr = in_ch.list_position[GA-1:0];
    end else if (state == cgpa_pkg::ST_RDWAIT) begin
      l_addr = res_slot[GA-1:0];
    end
  end

  // Bounds for the gene value at the current index in the check pass.
  logic [W-1:0] conn_hi, conn_lo, out_hi, out_lo;
  assign conn_hi = W'(n_in) + col * W'(n_rows) - 16'd1;
  assign conn_lo = col >= W'(lvl) ? W'(n_in) + W'(n_rows) * (col - W'(lvl)) : '0;
  assign out_hi = W'(n_in) + nodes - 16'd1;
  assign out_lo = W'(lvl) <= W'(n_cols) ? W'(n_in) + W'(n_rows) * (W'(n_cols) - W'(lvl))
                                        : '0;
  assign hi = idx < 16'd3 * nodes ? conn_hi : out_hi;
  assign lo = idx < 16'd3 * nodes ? conn_lo : out_lo;

  always_comb begin
    state_next = state;
    case (state)
      cgpa_pkg::ST_IDLE: begin
        if (acc && in_ch.action == cgpa_pkg::ACT_READ) begin
          state_next = cgpa_pkg::ST_RDWAIT;
        end else if (acc && in_ch.action == cgpa_pkg::ACT_ANALYSE) begin
          state_next = fits ? cgpa_pkg::ST_CHK_RD : cgpa_pkg::ST_RESULT;
        end
      end
      cgpa_pkg::ST_RDWAIT: state_next = cgpa_pkg::ST_RESULT;
      cgpa_pkg::ST_CHK_RD: state_next = cgpa_pkg::ST_CHK;
      cgpa_pkg::ST_CHK: begin
        state_next = cgpa_pkg::ST_CHK_RD;
        if (!res_ok) begin
          state_next = cgpa_pkg::ST_RESULT;
        end else if (idx == genome) begin
          state_next = cgpa_pkg::ST_CLR;
        end
      end
      cgpa_pkg::ST_CLR: begin
        if (idx + 16'd1 == W'(n_in) + nodes) begin
          state_next = cgpa_pkg::ST_OUT_RD;
        end
      end
      cgpa_pkg::ST_OUT_RD: state_next = cgpa_pkg::ST_OUT_MARK;
      cgpa_pkg::ST_OUT_MARK: begin
        state_next = cnt + 16'd1 == W'(n_out) ? cgpa_pkg::ST_SWEEP_RD : cgpa_pkg::ST_OUT_RD;
      end
      cgpa_pkg::ST_SWEEP_RD: begin
        state_next = idx + 16'd1 == W'(n_in) ? cgpa_pkg::ST_LIST_RD
                                             : cgpa_pkg::ST_SWEEP_MARK;
      end
      cgpa_pkg::ST_SWEEP_MARK: state_next = cgpa_pkg::ST_SWEEP_RD;
      cgpa_pkg::ST_LIST_RD: begin
        state_next = idx == W'(n_in) + nodes ? cgpa_pkg::ST_OUTLIST : cgpa_pkg::ST_LIST;
      end
      cgpa_pkg::ST_LIST: begin
        if (mode == 2'd0) begin
          if (!(m_rdata && idx >= W'(n_in))) begin
            state_next = cgpa_pkg::ST_LIST_RD;
          end
        end else if (sub == 2'd2) begin
          state_next = cgpa_pkg::ST_LIST_RD;
        end
      end
      cgpa_pkg::ST_OUTLIST: begin
        if (cnt + 16'd1 == W'(n_out)) begin
          state_next = cgpa_pkg::ST_RESULT;
        end
      end
      cgpa_pkg::ST_RESULT: state_next = cgpa_pkg::ST_IDLE;
      default: state_next = cgpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgpa_pkg::ST_IDLE;
      n_in <= 5'd1;
      n_out <= 4'd1;
      n_rows <= 7'd1;
      n_cols <= 7'd1;
      lvl <= 7'd1;
      n_fn <= 5'd1;
      gene_total <= '0;
      node_total <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          cgpa_pkg::REG_INPUTS: n_in <= cfg.data[4:0];
          cgpa_pkg::REG_OUTPUTS: n_out <= cfg.data[3:0];
          cgpa_pkg::REG_ROWS: n_rows <= cfg.data;
          cgpa_pkg::REG_COLUMNS: n_cols <= cfg.data;
          cgpa_pkg::REG_LEVELS: lvl <= cfg.data;
          cgpa_pkg::REG_FUNCTIONS: n_fn <= cfg.data[4:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        cgpa_pkg::ST_IDLE: begin
          idx <= '0; col <= '0; row <= '0; sub <= '0;
          res_ok <= fits;
          res_read <= in_ch.action == cgpa_pkg::ACT_READ;
          res_slot <= in_ch.list_position;
        end
        cgpa_pkg::ST_RDWAIT: ;
        cgpa_pkg::ST_CHK_RD: ;
        cgpa_pkg::ST_CHK: begin
          if (idx < genome) begin
            if (idx < 16'd3 * nodes && sub == 2'd0) begin
              if (W'(g_rdata) > W'(n_fn) - 16'd1) res_ok <= 1'b0;
            end else if (W'(g_rdata) > hi || W'(g_rdata) < lo) begin
              res_ok <= 1'b0;
            end
          end
          idx <= idx + 16'd1;
          if (sub == 2'd2) begin
            sub <= '0;
            if (row + 16'd1 == W'(n_rows)) begin
              row <= '0; col <= col + 16'd1;
            end else begin
              row <= row + 16'd1;
            end
          end else begin
            sub <= sub + 2'd1;
          end
          if (idx == genome) begin
            idx <= '0; cnt <= '0;
          end
        end
        cgpa_pkg::ST_CLR: begin
          idx <= idx + 16'd1;
          sub <= 2'd1;
        end
        cgpa_pkg::ST_OUT_RD: ;
        cgpa_pkg::ST_OUT_MARK: begin
          cnt <= cnt + 16'd1;
          idx <= W'(n_in) + nodes - 16'd1;
        end
        cgpa_pkg::ST_SWEEP_RD: begin
          if (idx + 16'd1 == W'(n_in)) begin
            idx <= '0; len <= '0; cnt <= '0; sub <= '0; mode <= '0;
          end
        end
        cgpa_pkg::ST_SWEEP_MARK: begin
          if (!m_rdata) begin
            idx <= idx - 16'd1;
          end else if (sub == 2'd2) begin
            sub <= 2'd1; idx <= idx - 16'd1;
          end else begin
            sub <= 2'd2;
          end
        end
        cgpa_pkg::ST_LIST_RD: begin
          if (idx == W'(n_in) + nodes) begin
            node_total <= cnt[6:0]; cnt <= '0;
          end
        end
        cgpa_pkg::ST_LIST: begin
          if (mode == 2'd0) begin
            if (m_rdata) begin
              cnt <= cnt + 16'd1;
              if (idx >= W'(n_in)) mode <= 2'd1;
              else idx <= idx + 16'd1;
            end else begin
              idx <= idx + 16'd1;
            end
          end else begin
            len <= len + 16'd1;
            if (sub == 2'd2) begin
              sub <= '0; mode <= '0; idx <= idx + 16'd1;
            end else begin
              sub <= sub + 2'd1;
            end
          end
        end
        cgpa_pkg::ST_OUTLIST: begin
          len <= len + 16'd1;
          cnt <= cnt + 16'd1;
          if (cnt + 16'd1 == W'(n_out)) gene_total <= 8'(len + 16'd1);
        end
        cgpa_pkg::ST_RESULT: begin
          out_ch.valid <= 1'b1;
          out_ch.active_node_count <= node_total;
          out_ch.active_gene_count <= gene_total;
          out_ch.chromosome_valid <= !res_read && res_ok;
          out_ch.entry_in_range <= res_read && res_slot < gene_total;
          out_ch.active_gene_slot <= res_read && res_slot < gene_total ? l_rdata : '0;
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != cgpa_pkg::ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    state == cgpa_pkg::ST_RESULT |=> out_ch.valid) else $error("result lost");
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    state == cgpa_pkg::ST_RDWAIT |=> state == cgpa_pkg::ST_RESULT) else $error("read path");
endmodule
`default_nettype wire
